/* sv/bitmap_page_allocator_core_assert.svh */
// assertion macros for the checker file of the page allocator
// depends on a clock named clk and an active-high reset named rst in scope
`ifndef BITMAP_PAGE_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication
`define BPA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bpa check failed");

// next-cycle implication
`define BPA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bpa check failed");

`endif

/* sv/bpa_pkg.sv */
// shared constants and types of the bitmap page allocator
// no dependencies
package bpa_pkg;

  localparam int MAX_PAGES  = 65536;
  localparam int WORD_W     = 64;
  localparam int WORDS      = MAX_PAGES / WORD_W;
  localparam int WADDR_W    = $clog2(WORDS);
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int PAGE_W     = $clog2(MAX_PAGES);
  localparam int CNT_W      = PAGE_W + 1;
  localparam int ADDR_W     = 48;
  localparam int PAGE_SHIFT = 12;
  localparam int PFN_W      = ADDR_W - PAGE_SHIFT;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic CFG_TRACKED_PAGES = 1'b0;
  localparam logic CFG_MEMORY_TOP    = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_COUNT = 2'd1,
    ST_NO_RUN    = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef struct packed {
    logic             hit;
    logic [BIT_W-1:0] bit_idx;
  } scan_res_t;

endpackage

/* sv/bitmap_page_allocator_core.sv */
// top level of the bitmap first-fit page allocator: sequencer, config, result register
// depends on bpa_pkg, bpa_ram, bpa_scan
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------
//  in       | in_valid / in_stall | mode, num_pages, phys_address
//  out      | out_valid/out_stall | status, alloc_address, free_count
//  cfg      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// after reset a clearing pass sets all 1024 bitmap words to used
// rejected requests pass from accept through S_FINISH to the result register
// allocate: scan of one word per cycle up to tracked_pages/64 words, then a
//   read-modify-write pass of one word per cycle over the run; the single ram
//   read port sets this rate
// free: one word per cycle over the words touched by the range
// one transaction at a time; a stalled result waits in the output register
module bitmap_page_allocator_core
  import bpa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              mode,
  input  logic [CNT_W-1:0]  num_pages,
  input  logic [ADDR_W-1:0] phys_address,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        status,
  output logic [ADDR_W-1:0] alloc_address,
  output logic [CNT_W-1:0]  free_count,
  // configuration channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [ADDR_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_FINISH
  } state_t;

  state_t state;

  // configuration registers
  logic [CNT_W-1:0]  tracked_pages;
  logic [ADDR_W-1:0] memory_top;

  // allocator state and request context
  logic [CNT_W-1:0]   avail_pages;
  logic [CNT_W-1:0]   req_count;
  logic               op_xor;
  logic [WADDR_W:0]   words_lim;
  logic [WADDR_W:0]   ptr;
  logic               tag_vld;
  logic [WADDR_W-1:0] tag_w;
  logic [WADDR_W-1:0] first_w;
  logic [WADDR_W-1:0] end_w;
  logic [BIT_W-1:0]   lo_bit;
  logic [BIT_W-1:0]   hi_bit;
  status_t            res_status;
  logic [PAGE_W-1:0]  res_page;

  // request decode
  logic               accept_in;
  logic [WADDR_W:0]   words_cfg;
  logic               alloc_bad;
  logic [ADDR_W:0]    free_end;
  logic               range_bad;
  logic [PFN_W-1:0]   first_pfn;
  logic               first_in;
  logic [CNT_W:0]     last_pfn;
  logic [PAGE_W-1:0]  last_clip;
  logic [CNT_W:0]     free_sum;
  logic [CNT_W-1:0]   free_sat;

  // scan and mark datapath
  scan_res_t          sres;
  logic [PAGE_W-1:0]  hit_end;
  logic [PAGE_W-1:0]  start_page;
  logic [BIT_W-1:0]   mask_lo;
  logic [BIT_W-1:0]   mask_hi;
  logic [WORD_W-1:0]  mask;
  logic [WORD_W-1:0]  new_word;
  logic               issue;
  logic               ram_we;
  logic [WADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;
  logic [WORD_W-1:0]  ram_rdata;

  assign in_stall  = (state != S_IDLE);
  assign accept_in = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // scan only whole words, clamped to the bitmap size
  assign words_cfg = (tracked_pages > CNT_W'(MAX_PAGES)) ? (WADDR_W+1)'(WORDS)
                                                         : tracked_pages[CNT_W-1:BIT_W];
  assign alloc_bad = (num_pages == '0) || (num_pages > avail_pages);

  // free range checks
  assign free_end  = (ADDR_W+1)'(phys_address) + ((ADDR_W+1)'(num_pages) << PAGE_SHIFT);
  assign range_bad = free_end > (ADDR_W+1)'(memory_top);
  assign first_pfn = phys_address[ADDR_W-1:PAGE_SHIFT];
  assign first_in  = (first_pfn < PFN_W'(MAX_PAGES));
  assign last_pfn  = (CNT_W+1)'(first_pfn[PAGE_W-1:0]) + (CNT_W+1)'(num_pages)
                     - (CNT_W+1)'(1);
  // pages past the bitmap are dropped from the toggle
  assign last_clip = (last_pfn[CNT_W:PAGE_W] != '0) ? {PAGE_W{1'b1}}
                                                   : last_pfn[PAGE_W-1:0];
  assign free_sum  = (CNT_W+1)'(avail_pages) + (CNT_W+1)'(num_pages);
  assign free_sat  = (free_sum > (CNT_W+1)'(MAX_PAGES)) ? CNT_W'(MAX_PAGES)
                                                       : free_sum[CNT_W-1:0];

  // run found: end page is this word and bit, start is count-1 pages back
  assign hit_end    = {tag_w, sres.bit_idx};
  assign start_page = PAGE_W'(CNT_W'(hit_end) + CNT_W'(1) - req_count);

  // per-word mask of the range being marked
  assign mask_lo  = (tag_w == first_w) ? lo_bit : '0;
  assign mask_hi  = (tag_w == end_w) ? hi_bit : {BIT_W{1'b1}};
  assign mask     = ({WORD_W{1'b1}} << mask_lo) & ({WORD_W{1'b1}} >> (~mask_hi));
  assign new_word = op_xor ? (ram_rdata ^ mask) : (ram_rdata | mask);

  // read issue, one word per cycle
  assign issue = ((state == S_SCAN) && (ptr < words_lim)) ||
                 ((state == S_MARK) && (ptr <= (WADDR_W+1)'(end_w)));

  assign ram_we    = (state == S_CLEAR) || ((state == S_MARK) && tag_vld);
  assign ram_waddr = (state == S_CLEAR) ? ptr[WADDR_W-1:0] : tag_w;
  assign ram_wdata = (state == S_CLEAR) ? {WORD_W{1'b1}} : new_word;

  bpa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS)
  ) u_bitmap (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ptr[WADDR_W-1:0]),
    .rd_data (ram_rdata)
  );

  bpa_scan u_scan (
    .clk   (clk),
    .rst   (rst),
    .start (accept_in),
    .step  ((state == S_SCAN) && tag_vld),
    .word  (ram_rdata),
    .need  (req_count),
    .res   (sres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      ptr           <= '0;
      tag_vld       <= 1'b0;
      out_valid     <= 1'b0;
      avail_pages   <= '0;
      tracked_pages <= CNT_W'(MAX_PAGES);
      memory_top    <= ADDR_W'(268435456);
    end else begin
      // config writes, taken in any state
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_TRACKED_PAGES) begin
          tracked_pages <= cfg_data[CNT_W-1:0];
        end else begin
          memory_top <= cfg_data;
        end
      end

      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      // read pipeline tag follows the issued address
      tag_vld <= issue;
      tag_w   <= ptr[WADDR_W-1:0];
      if (issue) begin
        ptr <= ptr + 1'b1;
      end

      unique case (state)
        S_CLEAR: begin
          ptr <= ptr + 1'b1;
          if (ptr[WADDR_W-1:0] == WADDR_W'(WORDS - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (accept_in) begin
            req_count <= num_pages;
            res_page  <= '0;
            ptr       <= '0;
            if (mode == MODE_ALLOC) begin
              op_xor    <= 1'b0;
              words_lim <= words_cfg;
              if (alloc_bad) begin
                res_status <= ST_BAD_COUNT;
                state      <= S_FINISH;
              end else if (words_cfg == '0) begin
                res_status <= ST_NO_RUN;
                state      <= S_FINISH;
              end else begin
                state <= S_SCAN;
              end
            end else begin
              op_xor <= 1'b1;
              if (range_bad) begin
                res_status <= ST_RANGE;
                state      <= S_FINISH;
              end else begin
                res_status  <= ST_OK;
                avail_pages <= free_sat;
                if ((num_pages != '0) && first_in) begin
                  first_w <= first_pfn[PAGE_W-1:BIT_W];
                  lo_bit  <= first_pfn[BIT_W-1:0];
                  end_w   <= last_clip[PAGE_W-1:BIT_W];
                  hi_bit  <= last_clip[BIT_W-1:0];
                  ptr     <= (WADDR_W+1)'(first_pfn[PAGE_W-1:BIT_W]);
                  state   <= S_MARK;
                end else begin
                  state <= S_FINISH;
                end
              end
            end
          end
        end

        S_SCAN: begin
          if (tag_vld) begin
            if (sres.hit) begin
              // claim the run, then set its bits
              res_status  <= ST_OK;
              res_page    <= start_page;
              avail_pages <= avail_pages - req_count;
              first_w     <= start_page[PAGE_W-1:BIT_W];
              lo_bit      <= start_page[BIT_W-1:0];
              end_w       <= tag_w;
              hi_bit      <= sres.bit_idx;
              ptr         <= (WADDR_W+1)'(start_page[PAGE_W-1:BIT_W]);
              tag_vld     <= 1'b0;
              state       <= S_MARK;
            end else if ((WADDR_W+1)'(tag_w) == words_lim - 1'b1) begin
              res_status <= ST_NO_RUN;
              state      <= S_FINISH;
            end
          end
        end

        S_MARK: begin
          if (tag_vld && (tag_w == end_w)) begin
            state <= S_FINISH;
          end
        end

        S_FINISH: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            status        <= res_status;
            alloc_address <= {{(ADDR_W-PAGE_W-PAGE_SHIFT){1'b0}}, res_page,
                              {PAGE_SHIFT{1'b0}}};
            free_count    <= avail_pages;
            state         <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/bpa_ram.sv */
// generic simple dual-port ram, one write port, one registered read port
// no dependencies
module bpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* sv/bpa_scan.sv */
// free-run finder: one bitmap word per step, carries the open run across words
// depends on bpa_pkg
module bpa_scan
  import bpa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              step,
  input  logic [WORD_W-1:0] word,
  input  logic [CNT_W-1:0]  need,
  output scan_res_t         res
);

  // q: one plus index of the last used bit at or below each position, 0 if none
  logic [BIT_W:0]  q [BIT_W+1][WORD_W];
  logic [CNT_W-1:0] run;
  logic [CNT_W-1:0] diff;
  logic             need_small;
  logic             diff_small;
  logic [WORD_W-1:0] hit_vec;

  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      q[0][b] = word[b] ? (BIT_W+1)'(b + 1) : '0;
    end
    for (int l = 0; l < BIT_W; l++) begin
      for (int b = 0; b < WORD_W; b++) begin
        if (b >= (1 << l) && q[l][b] == '0) begin
          q[l+1][b] = q[l][b - (1 << l)];
        end else begin
          q[l+1][b] = q[l][b];
        end
      end
    end
  end

  assign diff       = need - run;
  assign need_small = (need <= CNT_W'(WORD_W));
  assign diff_small = (diff <= CNT_W'(WORD_W));

  always_comb begin
    logic [BIT_W:0] len;
    for (int b = 0; b < WORD_W; b++) begin
      len = (BIT_W+1)'(b + 1) - q[BIT_W][b];
      if (q[BIT_W][b] == '0) begin
        // run reaches back into earlier words
        hit_vec[b] = diff_small && ((BIT_W+1)'(b + 1) >= diff[BIT_W:0]);
      end else begin
        hit_vec[b] = need_small && (len >= need[BIT_W:0]);
      end
    end
  end

  always_comb begin
    res.hit     = |hit_vec;
    res.bit_idx = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (hit_vec[b]) begin
        res.bit_idx = BIT_W'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || start) begin
      run <= '0;
    end else if (step) begin
      if (q[BIT_W][WORD_W-1] == '0) begin
        run <= run + CNT_W'(WORD_W);
      end else begin
        run <= CNT_W'((BIT_W+1)'(WORD_W) - q[BIT_W][WORD_W-1]);
      end
    end
  end

endmodule

/* sv/bpa_checker.sv */
// port-level checks for the page allocator, bound to the top level
// depends on bpa_pkg and bitmap_page_allocator_core_assert.svh
`include "bitmap_page_allocator_core_assert.svh"

module bpa_checker
  import bpa_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [1:0]        status,
  input logic [ADDR_W-1:0] alloc_address,
  input logic [CNT_W-1:0]  free_count
);

  // a failed transaction never reports an address
  `BPA_ASSERT_SAME(a_addr_zero_on_fail, out_valid && (status != ST_OK), alloc_address == '0)

  // addresses are page aligned and within the bitmap
  `BPA_ASSERT_SAME(a_addr_aligned, out_valid,
                   (alloc_address[PAGE_SHIFT-1:0] == '0) &&
                   (alloc_address[ADDR_W-1:PAGE_SHIFT] < PFN_W'(MAX_PAGES)))

  // free count saturates at the page total
  `BPA_ASSERT_SAME(a_free_bound, out_valid, free_count <= CNT_W'(MAX_PAGES))

  // busy right after taking a request
  `BPA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // a held result stays put
  `BPA_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(status) && $stable(alloc_address) &&
                   $stable(free_count))

endmodule

bind bitmap_page_allocator_core bpa_checker u_bpa_checker (.*);

/* tb/bitmap_page_allocator_core_test.sv */
// self-checking testbench for bitmap_page_allocator_core: directed and random alloc/free
// requests checked against a built-in first-fit bitmap predictor; depends on bpa_pkg
module bitmap_page_allocator_core_test;
  import bpa_pkg::*;

  // watchdog: cycles without any transaction before the run is declared hung
  localparam int unsigned HANG_LIMIT = 20000;

  typedef struct {
    logic              m;
    logic [CNT_W-1:0]  cnt;
    logic [ADDR_W-1:0] pa;
  } page_request_t;

  typedef struct {
    status_t           st;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  fc;
  } alloc_result_t;

  typedef struct {
    int unsigned first;
    int unsigned len;
  } page_run_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              mode = MODE_ALLOC;
  logic [CNT_W-1:0]  num_pages = '0;
  logic [ADDR_W-1:0] phys_address = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        status;
  logic [ADDR_W-1:0] alloc_address;
  logic [CNT_W-1:0]  free_count;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_index = CFG_TRACKED_PAGES;
  logic [ADDR_W-1:0] cfg_data = '0;

  // shadow of the block state and its registers
  logic [WORD_W-1:0] page_map [WORDS];
  int unsigned       avail_pages;
  logic [CNT_W-1:0]  tracked_cfg;
  logic [ADDR_W-1:0] mem_top_cfg;

  page_request_t request_queue [$];
  alloc_result_t expected_results [$];
  page_run_t     held_runs [$];

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          errors = 0;
  int          requests_sent = 0;
  int          cfg_writes = 0;
  int          status_seen [4] = '{0, 0, 0, 0};
  int unsigned quiet_cycles = 0;

  bitmap_page_allocator_core dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .num_pages     (num_pages),
    .phys_address  (phys_address),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .alloc_address (alloc_address),
    .free_count    (free_count),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic bit idles_now(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic logic [ADDR_W-1:0] page_addr(input int unsigned pg);
    return ADDR_W'(pg) << PAGE_SHIFT;
  endfunction

  // first-fit search from page 0 over whole tracked words, then mark the run used
  function automatic alloc_result_t predict_alloc(input logic [CNT_W-1:0] cnt);
    alloc_result_t r;
    logic [63:0]   lim;
    logic [63:0]   nwords;
    logic [63:0]   run_len;
    logic [63:0]   run_start;
    logic [63:0]   q;
    bit            found;
    r.st = ST_OK;
    r.addr = '0;
    run_len = 0;
    run_start = 0;
    found = 1'b0;
    if (cnt == 0 || cnt > avail_pages) begin
      r.st = ST_BAD_COUNT;
      return r;
    end
    lim = (tracked_cfg > MAX_PAGES) ? 64'(MAX_PAGES) : 64'(tracked_cfg);
    nwords = lim / WORD_W;
    for (int w = 0; w < nwords && !found; w++) begin
      if (page_map[w] == '1) begin
        run_len = 0;
      end else begin
        for (int b = 0; b < WORD_W && !found; b++) begin
          if (page_map[w][b]) begin
            run_len = 0;
          end else begin
            if (run_len == 0) run_start = w * WORD_W + b;
            run_len++;
            if (run_len == cnt) found = 1'b1;
          end
        end
      end
    end
    if (!found) begin
      r.st = ST_NO_RUN;
      return r;
    end
    for (int k = 0; k < cnt; k++) begin
      q = run_start + k;
      page_map[q[15:6]][q[5:0]] = 1'b1;
    end
    avail_pages -= cnt;
    r.addr = ADDR_W'(run_start << PAGE_SHIFT);
    return r;
  endfunction

  // toggle the page range; pages past the bitmap only add to the count
  function automatic status_t predict_free(input logic [CNT_W-1:0] cnt,
                                           input logic [ADDR_W-1:0] pa);
    logic [63:0] end_addr;
    logic [63:0] first;
    logic [63:0] p;
    end_addr = 64'(pa) + (64'(cnt) << PAGE_SHIFT);
    first = 64'(pa) >> PAGE_SHIFT;
    if (end_addr > 64'(mem_top_cfg)) return ST_RANGE;
    for (int k = 0; k < cnt; k++) begin
      p = first + k;
      if (p < MAX_PAGES) page_map[p[15:6]][p[5:0]] ^= 1'b1;
    end
    avail_pages += cnt;
    if (avail_pages > MAX_PAGES) avail_pages = MAX_PAGES;
    return ST_OK;
  endfunction

  function automatic alloc_result_t predict_request(input logic m,
                                                    input logic [CNT_W-1:0] cnt,
                                                    input logic [ADDR_W-1:0] pa);
    alloc_result_t r;
    if (m == MODE_ALLOC) begin
      r = predict_alloc(cnt);
    end else begin
      r.st = predict_free(cnt, pa);
      r.addr = '0;
    end
    r.fc = CNT_W'(avail_pages);
    return r;
  endfunction

  // request driver: one transaction per accept, idles at random between items
  always @(posedge clk) begin
    page_request_t req;
    alloc_result_t exp_r;
    page_run_t     run;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        exp_r = predict_request(mode, num_pages, phys_address);
        expected_results.push_back(exp_r);
        requests_sent++;
        // remember granted runs so later frees can hand them back
        if (mode == MODE_ALLOC && exp_r.st == ST_OK) begin
          run.first = int'(exp_r.addr >> PAGE_SHIFT);
          run.len = num_pages;
          held_runs.push_back(run);
        end
      end
      if (!in_valid || !in_stall) begin
        if (request_queue.size() != 0 && !idles_now(send_idle_pct)) begin
          req = request_queue.pop_front();
          in_valid <= 1'b1;
          mode <= req.m;
          num_pages <= req.cnt;
          phys_address <= req.pa;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: checks each accepted result against the oldest expectation
  always @(posedge clk) begin
    alloc_result_t exp_r;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no request outstanding");
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          status_seen[exp_r.st]++;
          if (status !== exp_r.st) begin
            $error("status: expected %0d, got %0d", exp_r.st, status);
            errors++;
          end
          if (alloc_address !== exp_r.addr) begin
            $error("alloc_address: expected 0x%0h, got 0x%0h", exp_r.addr, alloc_address);
            errors++;
          end
          if (free_count !== exp_r.fc) begin
            $error("free_count: expected %0d, got %0d", exp_r.fc, free_count);
            errors++;
          end
        end
      end
      out_stall <= idles_now(recv_idle_pct);
    end
  end

  // watchdog: any transaction on any channel counts as progress
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("bitmap_page_allocator_core test failed");
        $finish;
      end
    end
  end

  task automatic add_request(input logic m, input int unsigned cnt,
                             input logic [ADDR_W-1:0] pa);
    page_request_t req;
    req.m = m;
    req.cnt = CNT_W'(cnt);
    req.pa = pa;
    request_queue.push_back(req);
  endtask

  // wait until every request has been sent and answered
  task automatic drain();
    while (request_queue.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [ADDR_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
    if (idx == CFG_TRACKED_PAGES) tracked_cfg = data[CNT_W-1:0];
    else mem_top_cfg = data;
  endtask

  // mostly small allocs and frees of granted runs, plus range noise and bad requests
  task automatic make_random_request();
    int unsigned tp;
    int unsigned pick;
    int unsigned cnt;
    int unsigned idx;
    page_run_t   run;
    tp = (tracked_cfg > MAX_PAGES) ? MAX_PAGES : tracked_cfg;
    if (tp < WORD_W) tp = WORD_W;
    pick = $urandom_range(99);
    if (pick < 50) begin
      cnt = ($urandom_range(3) == 0) ? $urandom_range(17, 130) : $urandom_range(1, 16);
      add_request(MODE_ALLOC, cnt, ADDR_W'({$urandom(), $urandom()}));
    end else if (pick < 80 && held_runs.size() != 0) begin
      idx = $urandom_range(held_runs.size() - 1);
      run = held_runs[idx];
      held_runs.delete(idx);
      add_request(MODE_FREE, run.len, page_addr(run.first) | ADDR_W'($urandom_range(4095)));
    end else if (pick < 88) begin
      add_request(MODE_FREE, $urandom_range(1, 70),
                  page_addr($urandom_range(tp - 1)) | ADDR_W'($urandom_range(4095)));
    end else if (pick < 90) begin
      // anywhere in the address space, any size
      add_request(MODE_FREE, $urandom_range(MAX_PAGES), ADDR_W'({$urandom(), $urandom()}));
    end else if (pick < 92) begin
      // range ending exactly at the top of memory or one byte past it
      cnt = $urandom_range(1, 8);
      if (mem_top_cfg >= (ADDR_W'(cnt) << PAGE_SHIFT))
        add_request(MODE_FREE, cnt,
                    mem_top_cfg - (ADDR_W'(cnt) << PAGE_SHIFT) + ADDR_W'($urandom_range(1)));
      else
        add_request(MODE_FREE, cnt, '0);
    end else if (pick < 96) begin
      add_request(MODE_ALLOC, $urandom_range(MAX_PAGES), '0);
    end else begin
      add_request(1'($urandom_range(1)), 0, ADDR_W'($urandom_range(1) ? 0 : $urandom()));
    end
  endtask

  task automatic random_phase(input logic [ADDR_W-1:0] tracked, input logic [ADDR_W-1:0] top,
                              input int s_pct, input int r_pct, input int n);
    drain();
    write_register(CFG_TRACKED_PAGES, tracked);
    write_register(CFG_MEMORY_TOP, top);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < n; i++) begin
      // keep the queue short so frees see recently granted runs
      while (request_queue.size() >= 2) @(posedge clk);
      make_random_request();
    end
  endtask

  initial begin
    foreach (page_map[w]) page_map[w] = '1;
    avail_pages = 0;
    tracked_cfg = CNT_W'(MAX_PAGES);
    mem_top_cfg = 48'h1000_0000;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed part: whole bitmap tracked, memory top at its maximum
    send_idle_pct = 34;
    recv_idle_pct = 48;
    write_register(CFG_TRACKED_PAGES, ADDR_W'(MAX_PAGES));
    write_register(CFG_MEMORY_TOP, 48'hFFFF_FFFF_FFFF);
    add_request(MODE_ALLOC, 0, '0);                     // zero-page alloc
    add_request(MODE_ALLOC, 1, '0);                     // nothing free yet
    add_request(MODE_FREE, 0, 48'hFFFF_FFFF_FFFF);      // zero-page free, all address bits
    add_request(MODE_FREE, 64, '0);
    add_request(MODE_ALLOC, 1, '0);
    add_request(MODE_ALLOC, 64, '0);                    // more than the free count
    add_request(MODE_ALLOC, 63, '0);
    add_request(MODE_FREE, 128, page_addr(100) | 48'hABC);
    add_request(MODE_ALLOC, 100, '0);                   // run crosses a word boundary
    add_request(MODE_ALLOC, 28, '0);
    add_request(MODE_FREE, 4, page_addr(120));
    add_request(MODE_FREE, 8, page_addr(256));
    add_request(MODE_FREE, 4, page_addr(258));          // toggles free pages back to used
    add_request(MODE_ALLOC, 3, '0);
    add_request(MODE_ALLOC, 2, '0);
    add_request(MODE_FREE, 1, 48'hFFFF_FFFF_F000);      // ends past the top
    add_request(MODE_FREE, 1, 48'hFFFF_FFFF_E000);      // beyond the bitmap, count only
    add_request(MODE_FREE, MAX_PAGES, 48'h1_0000_0000); // count saturates
    add_request(MODE_ALLOC, MAX_PAGES, '0);             // no run that long
    add_request(MODE_FREE, MAX_PAGES, '0);              // flip the whole bitmap
    add_request(MODE_ALLOC, 4000, '0);
    add_request(MODE_ALLOC, MAX_PAGES, '0);
    add_request(MODE_FREE, MAX_PAGES, '0);              // flip it back

    // random phases over several register settings and idle patterns
    random_phase(ADDR_W'(1024), 48'h1000_0000, 34, 48, 180);
    // tracked_pages above the bitmap size with junk above bit 16, no usable memory
    random_phase(48'h5A5A_0001_FFFF, '0, 34, 48, 20);
    random_phase(ADDR_W'(512), 48'h200_0000, 48, 34, 180);
    random_phase('0, 48'hFFFF_FFFF_FFFF, 48, 34, 15);
    random_phase(ADDR_W'(1000), 48'h8000_0000, 0, 0, 160);

    drain();
    repeat (40) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      errors++;
    end
    $display("%0d requests checked across %0d register writes", requests_sent, cfg_writes);
    $display("status mix: ok %0d, bad count %0d, no run %0d, out of range %0d",
             status_seen[ST_OK], status_seen[ST_BAD_COUNT], status_seen[ST_NO_RUN],
             status_seen[ST_RANGE]);
    if (errors == 0) begin
      $display("bitmap_page_allocator_core test passed");
    end else begin
      $display("bitmap_page_allocator_core test failed");
    end
    $finish;
  end

endmodule
